### rtl/i2cm_pkg.sv
// i2cm_pkg: shared types and constants for the bit-level i2c master
// no dependencies; imported by i2c_bit_level_master_top
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
  localparam int HALF_W        = 16;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = HALF_W'(80);

  // command codes, also the current operation
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_FIRST = 3'd0;
  localparam phase_t PH_SCL   = 3'd1;
  localparam phase_t PH_PULL  = 3'd2;
  localparam phase_t PH_LAST  = 3'd3;
  localparam phase_t PH_END   = 3'd7;

endpackage

### rtl/i2c_bit_level_master_top.sv
// i2c_bit_level_master_top: open-drain i2c master sequencer, one item per tick
// depends on i2cm_pkg
//
// Usage
// - input channel (in_valid/in_stall): one item per bus tick, carrying a
//   command (start, stop, write byte, read byte or none), its operands and
//   the sampled sda level; commands are only taken while the master is idle
// - output channel (out_valid/out_stall): one result item per input item,
//   with the scl/sda pull-down drives, busy, done, last read byte and ack
// - cfg_wr_*: sets the half period in ticks; write only while idle (unchecked)
// Timing
// - an item is held in the input register, processed against the sequencer
//   state in one pass and lands in the output register
// - one item per cycle sustained unless the output stalls; the sequencer state
//   feeds back into the very next item, all within that single pass
// Reset
// - synchronous rst releases both lines in the sequencer state, clears it and
//   the valid flags and sets the half period to 80 ticks
// Stall
// - while the output item is stalled the input register holds its item and
//   in_stall is raised only when that register is full
module i2c_bit_level_master_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [i2cm_pkg::HALF_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  cmd,
  input  logic [7:0]                  data_byte,
  input  logic                        send_ack,
  input  logic                        sda_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        scl_drive_low,
  output logic                        sda_drive_low,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  read_byte,
  output logic                        ack_bit
);
  import i2cm_pkg::*;

  // configuration
  logic [HALF_W-1:0] half_period;

  // input register
  logic       in_full;
  logic [2:0] cmd_r;
  logic [7:0] data_r;
  logic       send_ack_r;
  logic       sda_r;

  // sequencer state
  op_t                  op, op_next;
  phase_t               phase, phase_next;
  logic [HALF_W-1:0]    wait_count, wait_count_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]           shift_reg, shift_reg_next;
  logic                 ack_choice, ack_choice_next;
  logic                 scl_low, scl_low_next;
  logic                 sda_low, sda_low_next;
  logic [7:0]           last_read, last_read_next;
  logic                 last_ack, last_ack_next;
  logic                 done_next;
  logic                 step;

  logic advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  // half period register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r      <= cmd;
      data_r     <= data_byte;
      send_ack_r <= send_ack;
      sda_r      <= sda_in;
    end
  end

  // next state: command launch, half-period wait, completion and pin steps
  always_comb begin
    op_next         = op;
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    ack_choice_next = ack_choice;
    scl_low_next    = scl_low;
    sda_low_next    = sda_low;
    last_read_next  = last_read;
    last_ack_next   = last_ack;
    done_next       = 1'b0;
    step            = 1'b0;

    if (op == OP_IDLE) begin
      if (cmd_r inside {OP_START, OP_STOP, OP_WRITE, OP_READ}) begin
        op_next         = op_t'(cmd_r);
        phase_next      = PH_FIRST;
        bit_count_next  = '0;
        shift_reg_next  = (cmd_r == OP_WRITE) ? data_r : 8'h00;
        ack_choice_next = send_ack_r;
        step            = 1'b1;
      end
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - HALF_W'(1);
    end else if (phase == PH_END) begin
      op_next    = OP_IDLE;
      phase_next = PH_FIRST;
      done_next  = 1'b1;
    end else begin
      step = 1'b1;
    end

    // one pin-change step, then a half period of waiting
    if (step) begin
      case (op_next)
        OP_START: begin
          case (phase_next)
            PH_FIRST: begin
              sda_low_next = 1'b0;
              phase_next   = PH_SCL;
            end
            PH_SCL: begin
              scl_low_next = 1'b0;
              phase_next   = PH_PULL;
            end
            PH_PULL: begin
              sda_low_next = 1'b1;
              phase_next   = PH_LAST;
            end
            PH_LAST: begin
              scl_low_next = 1'b1;
              phase_next   = PH_END;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_STOP: begin
          case (phase_next)
            PH_FIRST: begin
              sda_low_next = 1'b1;
              phase_next   = PH_SCL;
            end
            PH_SCL: begin
              scl_low_next = 1'b0;
              phase_next   = PH_PULL;
            end
            PH_PULL: begin
              sda_low_next = 1'b0;
              phase_next   = PH_END;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_WRITE: begin
          case (phase_next)
            PH_FIRST: begin
              // data bit msb first, then release for the ack slot
              if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                sda_low_next   = ~shift_reg_next[7];
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
              end else begin
                sda_low_next = 1'b0;
              end
              phase_next = PH_SCL;
            end
            PH_SCL: begin
              scl_low_next = 1'b0;
              if (bit_count_next >= BIT_CNT_W'(BITS_PER_BYTE)) begin
                last_ack_next = sda_r;
              end
              phase_next = PH_PULL;
            end
            PH_PULL: begin
              scl_low_next = 1'b1;
              if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                bit_count_next = bit_count_next + BIT_CNT_W'(1);
                phase_next     = PH_FIRST;
              end else begin
                phase_next = PH_END;
              end
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_READ: begin
          case (phase_next)
            PH_FIRST: begin
              // release sda for data, or drive the ack choice at the end
              if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                sda_low_next = 1'b0;
              end else begin
                sda_low_next = ack_choice_next;
              end
              phase_next = PH_SCL;
            end
            PH_SCL: begin
              scl_low_next = 1'b0;
              if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                shift_reg_next = {shift_reg_next[6:0], sda_r};
                if (bit_count_next == BIT_CNT_W'(BITS_PER_BYTE - 1)) begin
                  last_read_next = shift_reg_next;
                end
              end
              phase_next = PH_PULL;
            end
            PH_PULL: begin
              scl_low_next = 1'b1;
              if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                bit_count_next = bit_count_next + BIT_CNT_W'(1);
                phase_next = (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) ?
                             PH_SCL : PH_FIRST;
              end else begin
                phase_next = PH_END;
              end
            end
            default: phase_next = PH_END;
          endcase
        end
        default: phase_next = PH_END;
      endcase
      wait_count_next = half_period;
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_IDLE;
      phase      <= PH_FIRST;
      wait_count <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      ack_choice <= 1'b0;
      scl_low    <= 1'b0;
      sda_low    <= 1'b0;
      last_read  <= '0;
      last_ack   <= 1'b0;
    end else if (advance) begin
      op         <= op_next;
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      ack_choice <= ack_choice_next;
      scl_low    <= scl_low_next;
      sda_low    <= sda_low_next;
      last_read  <= last_read_next;
      last_ack   <= last_ack_next;
    end
  end

  // result item: output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= in_full;
    end
  end

  // result item: payload from the updated state
  always_ff @(posedge clk) begin
    if (advance) begin
      scl_drive_low <= scl_low_next;
      sda_drive_low <= sda_low_next;
      busy_res      <= (op_next != OP_IDLE);
      done_res      <= done_next;
      read_byte     <= last_read_next;
      ack_bit       <= last_ack_next;
    end
  end

`ifndef SYNTHESIS
  // a completing item never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while busy");

  // idle sequencer always rests at the first phase
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (op == OP_IDLE) |-> (phase == PH_FIRST))
    else $error("idle with non-zero phase");

  // bit counter never passes the ack slot
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BIT_CNT_W'(BITS_PER_BYTE))
    else $error("bit counter out of range");

  // a held input item stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(cmd_r) && $stable(sda_r)))
    else $error("input item lost while stalled");
`endif

endmodule
